[rtl/pti_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_pkg
// Shared constants for the padding-aware trilinear interpolator.
// ----------------------------------------------------------------------------
package pti_pkg;

   // Default datapath widths
   localparam int VOXEL_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   // Number of cell corners and padded-corner limit
   localparam int CORNERS    = 8;
   localparam int PAD_LIMIT  = 4;
   localparam int CNT_W      = 4;

   // CSR map
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_PADDING_VALUE = 1'b0;

endpackage

[rtl/padding_aware_trilinear_interp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padding_aware_trilinear_interp
// Masked trilinear interpolation with a programmable padding value.
// ----------------------------------------------------------------------------
//  Channel  Ports   Direction  Content
//  req      req_*   in         fractions, eight corners, inside mask
//  rsp      rsp_*   out        interpolated value, padded flag in tuser
//  csr      csr_*   in/out     padding_value at byte address 0
//
//  One request per cycle while the response side accepts; the path has
//  four arithmetic stages, one divider stage per quotient bit plus a
//  load stage, and the output register. Every stage has its own valid bit
//  and advances when the next one is empty or moving, so stalls on the
//  response side lose nothing. Reset is synchronous and clears only
//  valid bits and the padding register.
// ----------------------------------------------------------------------------
module padding_aware_trilinear_interp import pti_pkg::*; #(
   parameter int VOXEL_WIDTH = VOXEL_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   localparam int REQ_W = ((3 * FRAC_BITS + 8 * VOXEL_WIDTH + 8 + 7) / 8) * 8,
   localparam int RSP_W = ((VOXEL_WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // frac_x, frac_y, frac_z, corner_000 .. corner_111, inside_mask
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,
   // out_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   // is_padded
   output logic [0:0]            rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int VW = VOXEL_WIDTH;
   localparam int FB = FRAC_BITS;
   localparam int C0 = 3 * FB;

   logic [VW-1:0]      pad_ff;
   logic [VW-1:0]      corner [CORNERS];
   logic [VW-1:0]      w_corner [CORNERS];
   logic [3*FB:0]      w_wt [CORNERS];
   logic [CNT_W-1:0]   w_pcnt;
   logic               w_valid, w_ready;
   logic               a_valid, a_ready;
   logic signed [3*FB+VW+4:0] a_num;
   logic [3*FB:0]      a_wsum;
   logic               a_padded;
   logic [VW-1:0]      out_value;
   logic               is_padded;

   // Register write and readback
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == REG_PADDING_VALUE)) begin
         pad_ff <= VW'(csr_pwdata);
      end
   end
   assign csr_prdata = (csr_paddr[2] == REG_PADDING_VALUE) ? 32'($signed(pad_ff)) : '0;

   // Unpack corners
   for (genvar i = 0; i < CORNERS; i++) begin : g_corner
      assign corner[i] = req_tdata[C0 + i*VW +: VW];
   end

   pti_weight #(.VW(VW), .FB(FB)) u_weight (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .frac_x      (req_tdata[0 +: FB]),
      .frac_y      (req_tdata[FB +: FB]),
      .frac_z      (req_tdata[2*FB +: FB]),
      .corner      (corner),
      .inside_mask (req_tdata[C0 + 8*VW +: 8]),
      .pad_value   (pad_ff),
      .out_valid   (w_valid),
      .out_ready   (w_ready),
      .out_corner  (w_corner),
      .out_wt      (w_wt),
      .out_pcnt    (w_pcnt)
   );

   pti_accum #(.VW(VW), .FB(FB)) u_accum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (w_valid),
      .in_ready   (w_ready),
      .corner     (w_corner),
      .wt         (w_wt),
      .pcnt       (w_pcnt),
      .out_valid  (a_valid),
      .out_ready  (a_ready),
      .out_num    (a_num),
      .out_wsum   (a_wsum),
      .out_padded (a_padded)
   );

   pti_divide #(.VW(VW), .FB(FB)) u_divide (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (a_valid),
      .in_ready   (a_ready),
      .num        (a_num),
      .wsum       (a_wsum),
      .padded     (a_padded),
      .pad_value  (pad_ff),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_value  (out_value),
      .out_padded (is_padded)
   );

   assign rsp_tdata = RSP_W'(out_value);
   assign rsp_tuser = is_padded;

endmodule

[rtl/pti_weight.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_weight
// Two pipeline stages: axis factors and xy products, then the eight
// corner weights, zeroed for excluded corners, plus the padded count.
// ----------------------------------------------------------------------------
module pti_weight import pti_pkg::*; #(
   parameter int VW = VOXEL_WIDTH_DEF,
   parameter int FB = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [FB-1:0]        frac_x,
   input  logic [FB-1:0]        frac_y,
   input  logic [FB-1:0]        frac_z,
   input  logic [VW-1:0]        corner [CORNERS],
   input  logic [7:0]           inside_mask,
   input  logic [VW-1:0]        pad_value,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [VW-1:0]        out_corner [CORNERS],
   output logic [3*FB:0]        out_wt [CORNERS],
   output logic [CNT_W-1:0]     out_pcnt
);

   localparam int F1 = FB + 1;
   localparam int XW = 2 * F1;

   logic            va_ff, vb_ff, en_a, en_b;
   logic [F1-1:0]   fx1, fy1, fz1, fx0, fy0, fz0;
   logic [XW-1:0]   xy_ff [4];
   logic [XW-1:0]   xy_in [4];
   logic [F1-1:0]   az_ff [2];
   logic [VW-1:0]   ca_ff [CORNERS];
   logic [7:0]      inc_ff, inc_in;
   logic [CNT_W-1:0] pa_ff, pa_in;
   logic [VW-1:0]   cb_ff [CORNERS];
   logic [3*FB:0]   wt_ff [CORNERS];
   logic [CNT_W-1:0] pb_ff;

   // Stall chain
   assign en_b     = !vb_ff || out_ready;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   // Axis factors: frac for offset one, one minus frac for offset zero
   assign fx1 = {1'b0, frac_x};
   assign fy1 = {1'b0, frac_y};
   assign fz1 = {1'b0, frac_z};
   assign fx0 = {1'b1, {FB{1'b0}}} - fx1;
   assign fy0 = {1'b1, {FB{1'b0}}} - fy1;
   assign fz0 = {1'b1, {FB{1'b0}}} - fz1;

   // Products over x and y, include flags and padded count
   always_comb begin
      pa_in = '0;
      for (int k = 0; k < 4; k++) begin
         xy_in[k] = XW'(((k & 2) != 0 ? fx1 : fx0)) * XW'(((k & 1) != 0 ? fy1 : fy0));
      end
      for (int i = 0; i < CORNERS; i++) begin
         inc_in[i] = inside_mask[i] && (corner[i] != pad_value);
         if (inside_mask[i] && (corner[i] == pad_value)) begin
            pa_in = pa_in + CNT_W'(1);
         end
      end
   end

   // Stage A registers
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en_a) begin
         va_ff <= in_valid;
      end
      if (en_a) begin
         xy_ff  <= xy_in;
         az_ff[0] <= fz0;
         az_ff[1] <= fz1;
         ca_ff  <= corner;
         inc_ff <= inc_in;
         pa_ff  <= pa_in;
      end
   end

   // Stage B: full weights
   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en_b) begin
         vb_ff <= va_ff;
      end
      if (en_b) begin
         for (int i = 0; i < CORNERS; i++) begin
            wt_ff[i] <= inc_ff[i] ? (3*FB+1)'(xy_ff[i >> 1]) * (3*FB+1)'(az_ff[i & 1]) : '0;
         end
         cb_ff <= ca_ff;
         pb_ff <= pa_ff;
      end
   end

   assign out_valid  = vb_ff;
   assign out_corner = cb_ff;
   assign out_wt     = wt_ff;
   assign out_pcnt   = pb_ff;

endmodule

[rtl/pti_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_accum
// Two pipeline stages: value times weight with the weight sum, then the
// signed weighted sum and the padding decision.
// ----------------------------------------------------------------------------
module pti_accum import pti_pkg::*; #(
   parameter int VW = VOXEL_WIDTH_DEF,
   parameter int FB = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [VW-1:0]               corner [CORNERS],
   input  logic [3*FB:0]               wt [CORNERS],
   input  logic [CNT_W-1:0]            pcnt,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [3*FB+VW+4:0]   out_num,
   output logic [3*FB:0]               out_wsum,
   output logic                        out_padded
);

   localparam int WW = 3 * FB + 1;
   localparam int PW = WW + VW + 1;
   localparam int NW = PW + 3;

   logic                 vc_ff, vd_ff, en_c, en_d;
   logic signed [PW-1:0] prod_ff [CORNERS];
   logic [WW-1:0]        wsc_ff, wsc_in;
   logic [CNT_W-1:0]     pc_ff;
   logic signed [NW-1:0] num_ff, num_in;
   logic [WW-1:0]        wsd_ff;
   logic                 pd_ff;

   assign en_d     = !vd_ff || out_ready;
   assign en_c     = !vc_ff || en_d;
   assign in_ready = en_c;

   // Weight sum (cannot exceed one in the weight scale)
   always_comb begin
      wsc_in = '0;
      for (int i = 0; i < CORNERS; i++) begin
         wsc_in = wsc_in + wt[i];
      end
   end

   // Stage C: signed products
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (en_c) begin
         vc_ff <= in_valid;
      end
      if (en_c) begin
         for (int i = 0; i < CORNERS; i++) begin
            prod_ff[i] <= PW'($signed(corner[i])) * PW'($signed({1'b0, wt[i]}));
         end
         wsc_ff <= wsc_in;
         pc_ff  <= pcnt;
      end
   end

   // Sum the products
   always_comb begin
      num_in = '0;
      for (int i = 0; i < CORNERS; i++) begin
         num_in = num_in + NW'(prod_ff[i]);
      end
   end

   // Stage D
   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (en_d) begin
         vd_ff <= vc_ff;
      end
      if (en_d) begin
         num_ff <= num_in;
         wsd_ff <= wsc_ff;
         pd_ff  <= (pc_ff >= CNT_W'(PAD_LIMIT)) || (wsc_ff == '0);
      end
   end

   assign out_valid  = vd_ff;
   assign out_num    = num_ff;
   assign out_wsum   = wsd_ff;
   assign out_padded = pd_ff;

endmodule

[rtl/pti_divide.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_divide
// Pipelined restoring divider, one quotient bit per stage, followed by
// sign restore, padding select and the output register.
// ----------------------------------------------------------------------------
module pti_divide import pti_pkg::*; #(
   parameter int VW = VOXEL_WIDTH_DEF,
   parameter int FB = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [3*FB+VW+4:0]   num,
   input  logic [3*FB:0]               wsum,
   input  logic                        padded,
   input  logic [VW-1:0]               pad_value,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [VW-1:0]               out_value,
   output logic                        out_padded
);

   localparam int WW = 3 * FB + 1;
   localparam int NW = WW + VW + 4;
   localparam int QW = VW + 1;
   localparam int NS = VW + 2;

   logic [NW-1:0] rem_ff [NS];
   logic [QW-1:0] q_ff   [NS];
   logic [WW-1:0] ws_ff  [NS];
   logic          ng_ff  [NS];
   logic          pd_ff  [NS];
   logic          v_ff   [NS];
   logic          en     [NS+1];
   logic          ov_ff;
   logic [VW-1:0] val_ff, val_in;
   logic          opd_ff;

   // Stall chain
   assign en[NS] = !ov_ff || out_ready;
   for (genvar j = 0; j < NS; j++) begin : g_en
      assign en[j] = !v_ff[j] || en[j+1];
   end
   assign in_ready = en[0];

   // Load stage: sign and magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         v_ff[0] <= in_valid;
      end
      if (en[0]) begin
         rem_ff[0] <= num[NW-1] ? NW'(-num) : NW'(num);
         ng_ff[0]  <= num[NW-1];
         q_ff[0]   <= '0;
         ws_ff[0]  <= wsum;
         pd_ff[0]  <= padded;
      end
   end

   // One quotient bit per stage, most significant first
   for (genvar j = 0; j < NS - 1; j++) begin : g_step
      localparam int B = VW - j;
      logic [NW-1:0] d;
      logic          ge;
      assign d  = NW'(ws_ff[j]) << B;
      assign ge = rem_ff[j] >= d;
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else if (en[j+1]) begin
            v_ff[j+1] <= v_ff[j];
         end
         if (en[j+1]) begin
            rem_ff[j+1] <= ge ? rem_ff[j] - d : rem_ff[j];
            q_ff[j+1]   <= q_ff[j] | (ge ? (QW'(1) << B) : '0);
            ws_ff[j+1]  <= ws_ff[j];
            ng_ff[j+1]  <= ng_ff[j];
            pd_ff[j+1]  <= pd_ff[j];
         end
      end
   end

   // Restore sign or pick padding
   always_comb begin
      if (pd_ff[NS-1]) begin
         val_in = pad_value;
      end else if (ng_ff[NS-1]) begin
         val_in = VW'(-q_ff[NS-1]);
      end else begin
         val_in = VW'(q_ff[NS-1]);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en[NS]) begin
         ov_ff <= v_ff[NS-1];
      end
      if (en[NS]) begin
         val_ff <= val_in;
         opd_ff <= pd_ff[NS-1];
      end
   end

   assign out_valid  = ov_ff;
   assign out_value  = val_ff;
   assign out_padded = opd_ff;

endmodule

[sim/tb_padding_aware_trilinear_interp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_padding_aware_trilinear_interp
// Drives the interpolator with a directed table of cell requests and then
// with random requests under several padding values. Where no expected
// value is given, it predicts the response from the fractions, corners and
// inside mask, compares it field by field and idles both channels at random.
// ----------------------------------------------------------------------------
module tb_padding_aware_trilinear_interp import pti_pkg::*;;

   localparam int VW       = 16;
   localparam int REQ_W    = 184;
   localparam int LATENCY  = VW + 7;
   localparam int STUCK_LIMIT = 5000;

   typedef struct packed {
      logic [7:0]        mask;
      logic [7:0][15:0]  corner;   // corner[4x+2y+z]
      logic [15:0]       fz;
      logic [15:0]       fy;
      logic [15:0]       fx;
   } req_type;

   typedef struct {
      logic [15:0] value;
      logic        padded;
   } voxel_type;

   typedef struct {
      req_type     req;
      bit          typed;
      logic [15:0] value;
      logic        padded;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   voxel_type   pending_voxels[$];
   logic [15:0] pad_value = '0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          mismatches = 0;
   int          stuck_cycles = 0;
   row_type     rows[$];

   padding_aware_trilinear_interp dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   // Weighted average over non-padding in-image corners
   function automatic voxel_type interpolate(input req_type c, input logic [15:0] pad);
      voxel_type r;
      logic signed [127:0] acc, wsum, quo;
      logic [16:0] ax, ay, az;
      logic [63:0] wt;
      int npad;
      acc = '0;
      wsum = '0;
      npad = 0;
      for (int i = 0; i < 8; i++) begin
         ax = i[2] ? {1'b0, c.fx} : 17'h10000 - c.fx;
         ay = i[1] ? {1'b0, c.fy} : 17'h10000 - c.fy;
         az = i[0] ? {1'b0, c.fz} : 17'h10000 - c.fz;
         if (!c.mask[i]) continue;
         if (c.corner[i] == pad) begin
            npad++;
            continue;
         end
         wt = {47'd0, ax} * {47'd0, ay} * {47'd0, az};
         wsum = wsum + $signed({64'd0, wt});
         acc = acc + $signed({{112{c.corner[i][15]}}, c.corner[i]}) * $signed({64'd0, wt});
      end
      if (npad >= PAD_LIMIT || wsum == 0) begin
         r.value = pad;
         r.padded = 1'b1;
      end else begin
         quo = acc / wsum;
         r.value = quo[15:0];
         r.padded = 1'b0;
      end
      return r;
   endfunction

   function automatic void add_row(input logic [15:0] fx, fy, fz, input logic [127:0] corners,
                                   input logic [7:0] mask, input bit typed,
                                   input logic [15:0] value, input logic padded);
      row_type r;
      r.req.fx = fx;
      r.req.fy = fy;
      r.req.fz = fz;
      r.req.corner = corners;
      r.req.mask = mask;
      r.typed = typed;
      r.value = value;
      r.padded = padded;
      rows.push_back(r);
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
      mismatches++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   // Send one request, idling first at random; record its expected response
   task automatic send_request(input req_type c, input bit typed, input voxel_type typed_voxel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      pending_voxels.push_back(typed ? typed_voxel : interpolate(c, pad_value));
   endtask

   // Drain, then write one register through a setup and an access phase
   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      req_tvalid <= 1'b0;
      while (pending_voxels.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == CSR_ADDR_W'(REG_PADDING_VALUE)) pad_value = data[15:0];
   endtask

   function automatic logic [15:0] random_voxel(input logic [15:0] pad);
      case ($urandom_range(5))
         0, 1:    return pad;
         2:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         3:       return pad + 16'($urandom_range(4)) - 16'd2;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_fraction();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Accept responses and compare with the oldest expectation
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_voxels.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata, 16'h0);
         end else begin
            if (rsp_tdata !== pending_voxels[0].value)
               report_mismatch("out_value", rsp_tdata, pending_voxels[0].value);
            if (rsp_tuser[0] !== pending_voxels[0].padded)
               report_mismatch("is_padded", 16'(rsp_tuser), 16'(pending_voxels[0].padded));
            void'(pending_voxels.pop_front());
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_padding_aware_trilinear_interp failed");
            $finish;
         end
      end
   end

   initial begin
      voxel_type tv;
      req_type c;
      logic [15:0] pads[5];
      int idle_plan[3][2];
      int drain_cycles;

      // Directed table, padding value 0 after reset
      add_row(16'h1234, 16'h5678, 16'h9ABC, {8{16'h0077}}, 8'h00, 1, 16'h0000, 1);
      add_row(16'h1234, 16'h5678, 16'h9ABC, {8{16'h7FFF}}, 8'hFF, 1, 16'h7FFF, 0);
      add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, {8{16'h8000}}, 8'hFF, 1, 16'h8000, 0);
      add_row(16'h0000, 16'h0000, 16'h0000, {{7{16'h0011}}, 16'h8000}, 8'h01, 1, 16'h8000, 0);
      add_row(16'h0000, 16'h0000, 16'h0000, {16'h1234, {7{16'h0000}}}, 8'h80, 1, 16'h0000, 1);
      add_row(16'h4000, 16'h8000, 16'hC000, {{4{16'h0100}}, {4{16'h0000}}}, 8'hFF, 1, 16'h0000, 1);
      add_row(16'h8000, 16'h8000, 16'h8000, {{5{16'h0100}}, {3{16'h0000}}}, 8'hFF, 0, 16'h0, 0);
      add_row(16'h8000, 16'h0000, 16'h0000,
              {{3{16'h0000}}, 16'h0005, {3{16'h0000}}, 16'hFFFB}, 8'h11, 1, 16'h0000, 0);
      add_row(16'h0000, 16'h0000, 16'h0000, {{7{16'h0000}}, 16'h002A}, 8'h01, 1, 16'h002A, 0);
      add_row(16'hFFFF, 16'hFFFF, 16'hFFFF,
              {16'h7FFF, 16'h8000, 16'h1234, 16'hEDCB, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA},
              8'hFF, 0, 16'h0, 0);
      add_row(16'h0001, 16'hFFFE, 16'h8001,
              {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
              8'hAA, 0, 16'h0, 0);
      add_row(16'hAAAA, 16'h5555, 16'h0F0F,
              {16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC, 16'h7FFE, 16'h8001, 16'h0002, 16'hFFFD},
              8'h55, 0, 16'h0, 0);
      add_row(16'h7FFF, 16'h8000, 16'hFFFF,
              {16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h2000, 16'h3000, 16'h4000, 16'h5000},
              8'hFF, 0, 16'h0, 0);

      // Hold reset, then walk the table without idling
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         tv.value = rows[i].value;
         tv.padded = rows[i].padded;
         send_request(rows[i].req, rows[i].typed, tv);
      end

      // Random phases over several padding values, extremes among them
      pads[0] = 16'h7FFF;
      pads[1] = 16'h8000;
      pads[2] = 16'($urandom);
      pads[3] = 16'h0014;
      pads[4] = 16'h0000;
      idle_plan = '{'{32, 46}, '{46, 32}, '{0, 0}};
      for (int ph = 0; ph < 5; ph++) begin
         write_register(CSR_ADDR_W'(REG_PADDING_VALUE), {{16{pads[ph][15]}}, pads[ph]});
         // An address beyond the padding register must be ignored
         if (ph == 2) write_register(CSR_ADDR_W'(4), 32'h0000_1234);
         for (int n = 0; n < 100; n++) begin
            send_idle_pct = idle_plan[(n * 3) / 100][0];
            recv_stall_pct = idle_plan[(n * 3) / 100][1];
            if (n == 50) begin
               req_tvalid <= 1'b0;
               while (pending_voxels.size() != 0) @(posedge clock);
            end
            c.fx = random_fraction();
            c.fy = random_fraction();
            c.fz = random_fraction();
            for (int k = 0; k < 8; k++) c.corner[k] = random_voxel(pad_value);
            c.mask = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
            send_request(c, 0, tv);
         end
      end

      // Drain outstanding responses, then settle
      req_tvalid <= 1'b0;
      drain_cycles = 0;
      while (pending_voxels.size() != 0 && drain_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatches == 0 && pending_voxels.size() == 0) begin
         $display("tb_padding_aware_trilinear_interp passed");
      end else begin
         $display("tb_padding_aware_trilinear_interp failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/pti_pkg.sv
rtl/pti_weight.sv
rtl/pti_accum.sv
rtl/pti_divide.sv
rtl/padding_aware_trilinear_interp.sv
sim/tb_padding_aware_trilinear_interp.sv
